### hdl/vsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsws_pkg
// Shared constants, types and the reciprocal table for the window statistics.
// ----------------------------------------------------------------------------
package vsws_pkg;

  localparam int CHANNELS     = 3;
  localparam int WINDOW_DEPTH = 5;
  localparam int SAMPLE_WIDTH = 16;

  localparam int PTR_W   = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = SAMPLE_WIDTH + COUNT_W;

  // mean = (sum * floor(2^SUM_W / count)) >> SUM_W, then one correction step
  localparam int RECIP_SHIFT = SUM_W;
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RECIP_DEPTH = 2 ** COUNT_W;

  typedef logic [RECIP_DEPTH-1:0][RECIP_W-1:0] recip_table_t;

  // entry k holds floor(2^RECIP_SHIFT / k), entry zero is never used
  function automatic recip_table_t recip_build();
    recip_table_t tab;
    tab[0] = '0;
    for (int k = 1; k < RECIP_DEPTH; k++) begin
      tab[k] = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(k));
    end
    return tab;
  endfunction

  localparam recip_table_t RECIP_TABLE = recip_build();

  localparam int CH_TEMP   = 0;
  localparam int CH_PULSE  = 1;
  localparam int CH_OXYGEN = 2;

  typedef struct packed {
    logic               wr_en;
    logic               calc_en;
    logic [PTR_W-1:0]   wr_pos;
    logic [COUNT_W-1:0] count;
  } lane_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] max_val;
    logic [SAMPLE_WIDTH-1:0] min_val;
    logic [SUM_W-1:0]        sum;
    logic                    missing;
  } lane_stats_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] temperature_max;
    logic [SAMPLE_WIDTH-1:0] temperature_min;
    logic [SAMPLE_WIDTH-1:0] temperature_mean;
    logic [SAMPLE_WIDTH-1:0] pulse_max;
    logic [SAMPLE_WIDTH-1:0] pulse_min;
    logic [SAMPLE_WIDTH-1:0] pulse_mean;
    logic [SAMPLE_WIDTH-1:0] oxygen_max;
    logic [SAMPLE_WIDTH-1:0] oxygen_min;
    logic [SAMPLE_WIDTH-1:0] oxygen_mean;
    logic [COUNT_W-1:0]      window_count;
    logic [CHANNELS-1:0]     invalid_mask;
  } result_t;

endpackage

### hdl/vsws_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsws_in_if
// Input channel: one reading per vital sign with its present bit.
// ----------------------------------------------------------------------------
interface vsws_in_if;
  import vsws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] temperature_sample;
  logic [SAMPLE_WIDTH-1:0] pulse_sample;
  logic [SAMPLE_WIDTH-1:0] oxygen_sample;
  logic                    temperature_present;
  logic                    pulse_present;
  logic                    oxygen_present;

  modport source (
    output valid, temperature_sample, pulse_sample, oxygen_sample,
           temperature_present, pulse_present, oxygen_present,
    input  ready
  );
  modport sink (
    input  valid, temperature_sample, pulse_sample, oxygen_sample,
           temperature_present, pulse_present, oxygen_present,
    output ready
  );
endinterface

### hdl/vsws_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsws_out_if
// Result channel: per channel max, min and mean, fill count and invalid mask.
// ----------------------------------------------------------------------------
interface vsws_out_if;
  import vsws_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] temperature_max;
  logic [SAMPLE_WIDTH-1:0] temperature_min;
  logic [SAMPLE_WIDTH-1:0] temperature_mean;
  logic [SAMPLE_WIDTH-1:0] pulse_max;
  logic [SAMPLE_WIDTH-1:0] pulse_min;
  logic [SAMPLE_WIDTH-1:0] pulse_mean;
  logic [SAMPLE_WIDTH-1:0] oxygen_max;
  logic [SAMPLE_WIDTH-1:0] oxygen_min;
  logic [SAMPLE_WIDTH-1:0] oxygen_mean;
  logic [COUNT_W-1:0]      window_count;
  logic [CHANNELS-1:0]     invalid_mask;

  modport source (
    output valid, temperature_max, temperature_min, temperature_mean,
           pulse_max, pulse_min, pulse_mean, oxygen_max, oxygen_min,
           oxygen_mean, window_count, invalid_mask,
    input  ready
  );
  modport sink (
    input  valid, temperature_max, temperature_min, temperature_mean,
           pulse_max, pulse_min, pulse_mean, oxygen_max, oxygen_min,
           oxygen_mean, window_count, invalid_mask,
    output ready
  );
endinterface

### hdl/vital_sign_window_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vital_sign_window_statistics_unit
// Sliding window max, min and mean for temperature, pulse and SpO2.
// ----------------------------------------------------------------------------
// in_ch takes one item per reading set: three 16-bit samples, each with a
// present bit. out_ch gives one item for every input item: max, min and
// truncated mean per channel over the last five readings, the number held
// and a mask of channels whose window still holds a missing reading (their
// statistics read as zero).
// An item is taken in the idle state; the lanes then register their
// statistics in the stats state, the mean multiply is registered in the
// multiply state, and the result register loads in the finish state. No new
// item is taken until the sequencer is back in idle after this single
// stats / multiply / finish sequence that all three lanes share.
// The result register decouples the sides: the next item is accepted while
// a result waits; if the receiver still holds the previous result when the
// next one is finished, the sequencer waits in its last step.
// Reset clears the fill count, write pointer, sequencer and result valid;
// the windows need no clearing as only written entries are read.
// ----------------------------------------------------------------------------
module vital_sign_window_statistics_unit (
  input logic     clk,
  input logic     rst_n,
  vsws_in_if.sink    in_ch,
  vsws_out_if.source out_ch
);
  import vsws_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STATS = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   write_pos_r, write_pos_nxt;
  logic [COUNT_W-1:0] fill_count_r, fill_count_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;
  result_t            merged;

  logic        in_fire;
  logic        load_out;
  lane_ctrl_t  lane_ctrl;
  lane_stats_t stats [CHANNELS];

  logic [SAMPLE_WIDTH-1:0] sample_c  [CHANNELS];
  logic                    present_c [CHANNELS];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  assign sample_c[CH_TEMP]    = in_ch.temperature_sample;
  assign sample_c[CH_PULSE]   = in_ch.pulse_sample;
  assign sample_c[CH_OXYGEN]  = in_ch.oxygen_sample;
  assign present_c[CH_TEMP]   = in_ch.temperature_present;
  assign present_c[CH_PULSE]  = in_ch.pulse_present;
  assign present_c[CH_OXYGEN] = in_ch.oxygen_present;

  always_comb begin
    lane_ctrl.wr_en   = in_fire;
    lane_ctrl.calc_en = (state_r == ST_STATS);
    lane_ctrl.wr_pos  = write_pos_r;
    lane_ctrl.count   = fill_count_r;
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    vsws_lane u_lane (
      .clk     (clk),
      .ctrl    (lane_ctrl),
      .sample  (sample_c[c]),
      .present (present_c[c]),
      .stats   (stats[c])
    );
  end

  vsws_merge u_merge (
    .clk    (clk),
    .mul_en (state_r == ST_MUL),
    .count  (fill_count_r),
    .stats  (stats),
    .result (merged)
  );

  always_comb begin
    state_nxt      = state_r;
    write_pos_nxt  = write_pos_r;
    fill_count_nxt = fill_count_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt     = ST_STATS;
          write_pos_nxt = (write_pos_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                                                    : write_pos_r + 1'b1;
          if (fill_count_r != COUNT_W'(WINDOW_DEPTH)) fill_count_nxt = fill_count_r + 1'b1;
        end
      end
      ST_STATS: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_pos_r  <= '0;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_pos_r  <= write_pos_nxt;
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= merged;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.temperature_max  = out_r.temperature_max;
  assign out_ch.temperature_min  = out_r.temperature_min;
  assign out_ch.temperature_mean = out_r.temperature_mean;
  assign out_ch.pulse_max        = out_r.pulse_max;
  assign out_ch.pulse_min        = out_r.pulse_min;
  assign out_ch.pulse_mean       = out_r.pulse_mean;
  assign out_ch.oxygen_max       = out_r.oxygen_max;
  assign out_ch.oxygen_min       = out_r.oxygen_min;
  assign out_ch.oxygen_mean      = out_r.oxygen_mean;
  assign out_ch.window_count     = out_r.window_count;
  assign out_ch.invalid_mask     = out_r.invalid_mask;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_count_r <= COUNT_W'(WINDOW_DEPTH)) && (write_pos_r < PTR_W'(WINDOW_DEPTH)))
    else $error("fill count or write pointer out of range");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.window_count != '0)
    else $error("result with empty window");

  a_temp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.invalid_mask[CH_TEMP]) |->
      (out_r.temperature_min <= out_r.temperature_mean) &&
      (out_r.temperature_mean <= out_r.temperature_max))
    else $error("temperature mean outside min and max");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.invalid_mask[CH_PULSE]) |->
      (out_r.pulse_max == '0) && (out_r.pulse_min == '0) && (out_r.pulse_mean == '0))
    else $error("invalid pulse channel with nonzero statistics");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_STATS) && (fill_count_r != '0))
    else $error("accepted item did not start the sequence");
`endif

endmodule

### hdl/vsws_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsws_lane
// One channel: holds the sample window and finds max, min, sum and missing.
// ----------------------------------------------------------------------------
module vsws_lane (
  input  logic                              clk,
  input  vsws_pkg::lane_ctrl_t              ctrl,
  input  logic [vsws_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                              present,
  output vsws_pkg::lane_stats_t             stats
);
  import vsws_pkg::*;

  logic [SAMPLE_WIDTH-1:0] win_r [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] mark_r;
  lane_stats_t             stats_r;
  lane_stats_t             stats_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      win_r[ctrl.wr_pos]  <= present ? sample : '0;
      mark_r[ctrl.wr_pos] <= ~present;
    end
    if (ctrl.calc_en) begin
      stats_r <= stats_nxt;
    end
  end

  // only the first count entries have been written
  always_comb begin
    stats_nxt.max_val = '0;
    stats_nxt.min_val = '1;
    stats_nxt.sum     = '0;
    stats_nxt.missing = 1'b0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (COUNT_W'(i) < ctrl.count) begin
        if (mark_r[i]) begin
          stats_nxt.missing = 1'b1;
        end else begin
          if (win_r[i] > stats_nxt.max_val) stats_nxt.max_val = win_r[i];
          if (win_r[i] < stats_nxt.min_val) stats_nxt.min_val = win_r[i];
          stats_nxt.sum = stats_nxt.sum + SUM_W'(win_r[i]);
        end
      end
    end
  end

  assign stats = stats_r;

endmodule

### hdl/vsws_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsws_merge
// Combines the lane results: mean by reciprocal multiply, zeroing, mask.
// ----------------------------------------------------------------------------
module vsws_merge (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic [vsws_pkg::COUNT_W-1:0] count,
  input  vsws_pkg::lane_stats_t        stats [vsws_pkg::CHANNELS],
  output vsws_pkg::result_t            result
);
  import vsws_pkg::*;

  logic [PROD_W-1:0]       prod    [CHANNELS];
  logic [SUM_W-1:0]        q_est_r [CHANNELS];
  logic [SUM_W+COUNT_W-1:0] back   [CHANNELS];
  logic [SUM_W+COUNT_W-1:0] rem    [CHANNELS];
  logic [SUM_W-1:0]        quot    [CHANNELS];
  logic [SAMPLE_WIDTH-1:0] max_c   [CHANNELS];
  logic [SAMPLE_WIDTH-1:0] min_c   [CHANNELS];
  logic [SAMPLE_WIDTH-1:0] mean_c  [CHANNELS];
  logic [CHANNELS-1:0]     bad;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      prod[c] = PROD_W'(stats[c].sum) * PROD_W'(RECIP_TABLE[count]);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        q_est_r[c] <= prod[c][RECIP_SHIFT +: SUM_W];
      end
    end
  end

  // estimate is exact or one short
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      back[c] = (SUM_W + COUNT_W)'(q_est_r[c]) * (SUM_W + COUNT_W)'(count);
      rem[c]  = (SUM_W + COUNT_W)'(stats[c].sum) - back[c];
      quot[c] = (rem[c] >= (SUM_W + COUNT_W)'(count)) ? q_est_r[c] + 1'b1 : q_est_r[c];
      bad[c]  = stats[c].missing;
      max_c[c]  = bad[c] ? '0 : stats[c].max_val;
      min_c[c]  = bad[c] ? '0 : stats[c].min_val;
      mean_c[c] = bad[c] ? '0 : quot[c][SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    result.temperature_max  = max_c[CH_TEMP];
    result.temperature_min  = min_c[CH_TEMP];
    result.temperature_mean = mean_c[CH_TEMP];
    result.pulse_max        = max_c[CH_PULSE];
    result.pulse_min        = min_c[CH_PULSE];
    result.pulse_mean       = mean_c[CH_PULSE];
    result.oxygen_max       = max_c[CH_OXYGEN];
    result.oxygen_min       = min_c[CH_OXYGEN];
    result.oxygen_mean      = mean_c[CH_OXYGEN];
    result.window_count     = count;
    result.invalid_mask     = bad;
  end

endmodule

### bench/window_stats_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stats_monitor
// Watches both channels, predicts each result and compares it as it leaves.
// ----------------------------------------------------------------------------
// Every accepted reading set is folded into a private copy of the three
// five-deep windows. The max, min and truncated mean per channel, the fill
// count and the invalid mask are kept in a small ring. Each accepted result
// is checked field by field against the oldest one held.
// ----------------------------------------------------------------------------
module window_stats_monitor (
  input  logic        clk,
  input  logic        rst_n,
  vsws_in_if          in_mon,
  vsws_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import vsws_pkg::*;

  localparam int RING_DEPTH = 16;

  logic [SAMPLE_WIDTH-1:0] readings  [CHANNELS][WINDOW_DEPTH];
  logic [CHANNELS-1:0]     gap_marks [WINDOW_DEPTH];
  int unsigned             held;
  int unsigned             slot;
  int unsigned             errors = 0;
  result_t                 expect_ring [RING_DEPTH];
  int unsigned             ring_head;
  int unsigned             ring_tail;
  int unsigned             ring_fill;

  assign mismatches = errors;

  // writes one reading set into the windows and returns the statistics after it
  function automatic result_t slide_window(input logic [SAMPLE_WIDTH-1:0] t,
                                           input logic [SAMPLE_WIDTH-1:0] p,
                                           input logic [SAMPLE_WIDTH-1:0] o,
                                           input logic [CHANNELS-1:0]     present);
    result_t                 r;
    logic [SAMPLE_WIDTH-1:0] fresh [CHANNELS];
    logic [SAMPLE_WIDTH-1:0] stats [CHANNELS][3];
    logic [SAMPLE_WIDTH-1:0] hi;
    logic [SAMPLE_WIDTH-1:0] lo;
    logic [CHANNELS-1:0]     bad;
    int unsigned             total;
    int                      c;
    int                      i;
    fresh[CH_TEMP]   = t;
    fresh[CH_PULSE]  = p;
    fresh[CH_OXYGEN] = o;
    // a missing reading is held as zero and only its mark matters
    for (c = 0; c < CHANNELS; c++) begin
      readings[c][slot] = present[c] ? fresh[c] : '0;
    end
    gap_marks[slot] = ~present;
    slot = (slot + 1) % WINDOW_DEPTH;
    if (held < WINDOW_DEPTH) held++;
    bad = '0;
    for (c = 0; c < CHANNELS; c++) begin
      hi    = '0;
      lo    = '1;
      total = 0;
      for (i = 0; i < held; i++) begin
        if (gap_marks[i][c]) begin
          bad[c] = 1'b1;
        end else begin
          if (readings[c][i] > hi) hi = readings[c][i];
          if (readings[c][i] < lo) lo = readings[c][i];
          total += readings[c][i];
        end
      end
      if (bad[c]) begin
        stats[c][0] = '0;
        stats[c][1] = '0;
        stats[c][2] = '0;
      end else begin
        stats[c][0] = hi;
        stats[c][1] = lo;
        stats[c][2] = SAMPLE_WIDTH'(total / held);
      end
    end
    r.temperature_max  = stats[CH_TEMP][0];
    r.temperature_min  = stats[CH_TEMP][1];
    r.temperature_mean = stats[CH_TEMP][2];
    r.pulse_max        = stats[CH_PULSE][0];
    r.pulse_min        = stats[CH_PULSE][1];
    r.pulse_mean       = stats[CH_PULSE][2];
    r.oxygen_max       = stats[CH_OXYGEN][0];
    r.oxygen_min       = stats[CH_OXYGEN][1];
    r.oxygen_mean      = stats[CH_OXYGEN][2];
    r.window_count     = COUNT_W'(held);
    r.invalid_mask     = bad;
    return r;
  endfunction

  function automatic void compare_field(input string                   name,
                                        input logic [SAMPLE_WIDTH-1:0] want,
                                        input logic [SAMPLE_WIDTH-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      held      = 0;
      slot      = 0;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
    end else begin
      // results first: one leaving now cannot belong to a reading taken now
      if (out_mon.valid && out_mon.ready) begin
        if (ring_fill == 0) begin
          $error("result item with no reading set waiting");
          errors++;
        end else begin
          want      = expect_ring[ring_head];
          ring_head = (ring_head + 1) % RING_DEPTH;
          ring_fill--;
          compare_field("temperature_max",  want.temperature_max,  out_mon.temperature_max);
          compare_field("temperature_min",  want.temperature_min,  out_mon.temperature_min);
          compare_field("temperature_mean", want.temperature_mean, out_mon.temperature_mean);
          compare_field("pulse_max",        want.pulse_max,        out_mon.pulse_max);
          compare_field("pulse_min",        want.pulse_min,        out_mon.pulse_min);
          compare_field("pulse_mean",       want.pulse_mean,       out_mon.pulse_mean);
          compare_field("oxygen_max",       want.oxygen_max,       out_mon.oxygen_max);
          compare_field("oxygen_min",       want.oxygen_min,       out_mon.oxygen_min);
          compare_field("oxygen_mean",      want.oxygen_mean,      out_mon.oxygen_mean);
          compare_field("window_count",     want.window_count,     out_mon.window_count);
          compare_field("invalid_mask",     want.invalid_mask,     out_mon.invalid_mask);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (ring_fill == RING_DEPTH) begin
          $error("more reading sets in flight than the monitor can hold");
          errors++;
        end else begin
          expect_ring[ring_tail] = slide_window(in_mon.temperature_sample,
                                                in_mon.pulse_sample,
                                                in_mon.oxygen_sample,
                                                {in_mon.oxygen_present,
                                                 in_mon.pulse_present,
                                                 in_mon.temperature_present});
          ring_tail = (ring_tail + 1) % RING_DEPTH;
          ring_fill++;
        end
      end
    end
    outstanding = ring_fill;
  end

endmodule

### bench/vital_sign_window_statistics_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vital_sign_window_statistics_unit_tb
// Drives reading sets into the window statistics unit and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run covers extreme samples, each channel missing alone,
// all missing, window fill, wrap and a missing reading ageing out. Random
// reading sets follow in three phases of sender and receiver idling, with a
// long receiver hold-off and a sender pause until all results are back.
// Prediction and comparison sit in window_stats_monitor.
// ----------------------------------------------------------------------------
module vital_sign_window_statistics_unit_tb;
  import vsws_pkg::*;

  localparam int STALL_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES  = 200;
  localparam int DRAIN_CYCLES     = 16;
  localparam int RANDOM_PER_PHASE = 215;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned tx_idle_pct = 32;
  int unsigned rx_idle_pct = 78;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches;
  int unsigned outstanding;

  vsws_in_if  in_ch ();
  vsws_out_if out_ch ();

  vital_sign_window_statistics_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  window_stats_monitor u_stats_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  // result side: random stalls, or a long hold-off when asked for
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic offer_reading(input logic [15:0] t, input logic [15:0] p,
                               input logic [15:0] o, input logic [2:0] present);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid               <= 1'b1;
    in_ch.temperature_sample  <= t;
    in_ch.pulse_sample        <= p;
    in_ch.oxygen_sample       <= o;
    in_ch.temperature_present <= present[CH_TEMP];
    in_ch.pulse_present       <= present[CH_PULSE];
    in_ch.oxygen_present      <= present[CH_OXYGEN];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic offer_random();
    logic [15:0] s [3];
    logic [2:0]  present;
    int          c;
    for (c = 0; c < CHANNELS; c++) begin
      // extremes often enough to land on the top and bottom of the range
      case ($urandom_range(7))
        0:       s[c] = 16'h0000;
        1:       s[c] = 16'hFFFF;
        default: s[c] = 16'($urandom_range(65535));
      endcase
      present[c] = ($urandom_range(9) != 0);
    end
    offer_reading(s[CH_TEMP], s[CH_PULSE], s[CH_OXYGEN], present);
  endtask

  initial begin : stimulus
    int n;
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.temperature_sample  = '0;
    in_ch.pulse_sample        = '0;
    in_ch.oxygen_sample       = '0;
    in_ch.temperature_present = 1'b0;
    in_ch.pulse_present       = 1'b0;
    in_ch.oxygen_present      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: fill, wrap, each channel missing, missing reading ageing out
    offer_reading(16'h0000, 16'h0000, 16'h0000, 3'b111);
    offer_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
    offer_reading(16'h1234, 16'hFFFF, 16'h0000, 3'b110);
    offer_reading(16'h0001, 16'h8000, 16'h7FFF, 3'b111);
    offer_reading(16'h8000, 16'h0001, 16'hFFFF, 3'b111);
    offer_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
    offer_reading(16'h0000, 16'hBEEF, 16'h0000, 3'b101);
    offer_reading(16'h2540, 16'h4800, 16'h6200, 3'b111);
    offer_reading(16'hABCD, 16'h5555, 16'hAAAA, 3'b000);
    offer_reading(16'hFFFF, 16'hFFFF, 16'hC0DE, 3'b011);
    repeat (5) offer_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
    offer_reading(16'h0000, 16'h0000, 16'h0000, 3'b111);
    offer_reading(16'hFFFF, 16'h0000, 16'hFFFF, 3'b111);
    offer_reading(16'h0000, 16'hFFFF, 16'h0000, 3'b111);
    offer_reading(16'h2500, 16'h4800, 16'h6200, 3'b111);
    offer_reading(16'h2501, 16'h4801, 16'h6201, 3'b111);

    for (n = 0; n < RANDOM_PER_PHASE; n++) offer_random();

    tx_idle_pct = 78;
    rx_idle_pct = 32;
    for (n = 0; n < RANDOM_PER_PHASE; n++) offer_random();

    // no idling; the receiver first holds off long enough to back the input up
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_off_req = 1'b1;
    for (n = 0; n < 220; n++) begin
      if (n == 120) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
      end
      offer_random();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### vital_sign_window_statistics_unit.f
hdl/vsws_pkg.sv
hdl/vsws_in_if.sv
hdl/vsws_out_if.sv
hdl/vsws_lane.sv
hdl/vsws_merge.sv
hdl/vital_sign_window_statistics_unit.sv
bench/window_stats_monitor.sv
bench/vital_sign_window_statistics_unit_tb.sv
